FILE: rtl/scfq_pkg.sv
// ----------------------------------------------------------------------------
// scfq_pkg
// Types, sizes and byte codes shared by the SLIP command frame queue.
// ----------------------------------------------------------------------------
package scfq_pkg;

	localparam int QUEUE_DEPTH = 16;   // command store entries, 2..64
	localparam int FRAME_BYTES = 7;    // longest accepted frame, 1..7
	localparam int BUF_SLOTS   = 7;    // bytes held per command

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOT_W = $clog2(BUF_SLOTS);
	localparam int BCNT_W = $clog2(BUF_SLOTS + 1);

	localparam logic [7:0] FEND     = 8'hC0;
	localparam logic [7:0] FESC     = 8'hDB;
	localparam logic [7:0] TFEND    = 8'hDC;
	localparam logic [7:0] TFESC    = 8'hDD;
	localparam logic [1:0] TAG_MASK = 2'h3;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_ABSORBED  = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_TOO_LONG  = 3'd2,
		ST_FULL      = 3'd3,
		ST_POP_OK    = 3'd4,
		ST_POP_EMPTY = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]                 tag;
		logic [BUF_SLOTS-1:0][7:0] bytes;
	} entry_t;

	// Translate the byte that follows an escape.
	function automatic logic [7:0] unescape(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b == TFEND) begin
			r = FEND;
		end else if (b == TFESC) begin
			r = FESC;
		end
		return r;
	endfunction

endpackage

FILE: rtl/scfq_in_if.sv
// ----------------------------------------------------------------------------
// scfq_in_if
// Input channel: one received byte or one pop request per transaction.
// ----------------------------------------------------------------------------
interface scfq_in_if;
	import scfq_pkg::*;

	logic       valid;
	logic       ready;
	op_t        op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink   (input valid, input op, input rx_byte, output ready);

endinterface

FILE: rtl/scfq_out_if.sv
// ----------------------------------------------------------------------------
// scfq_out_if
// Result channel: status, popped command and queue fill per transaction.
// ----------------------------------------------------------------------------
interface scfq_out_if;
	import scfq_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	logic [1:0]       queue_sel;
	logic [7:0]       cmd_code;
	logic [7:0]       param_one;
	logic [7:0]       param_two;
	logic [7:0]       param_three;
	logic [7:0]       param_four;
	logic [7:0]       param_five;
	logic [7:0]       param_six;
	logic [CNT_W-1:0] queued_count;

	modport source (
		output valid, output status, output queue_sel, output cmd_code,
		output param_one, output param_two, output param_three,
		output param_four, output param_five, output param_six,
		output queued_count, input ready
	);
	modport sink (
		input valid, input status, input queue_sel, input cmd_code,
		input param_one, input param_two, input param_three,
		input param_four, input param_five, input param_six,
		input queued_count, output ready
	);

endinterface

FILE: rtl/slip_command_frame_queue_core.sv
// ----------------------------------------------------------------------------
// slip_command_frame_queue_core
// SLIP deframer feeding a circular command store with pop access.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_in carries one transaction per item: op = OP_BYTE delivers a raw
//   serial byte for SLIP decoding, op = OP_POP asks for the oldest queued
//   command. cmd_out returns exactly one result per input transaction, in
//   order: a status code, the popped command (zero unless the pop
//   succeeded) and the number of commands held after that item.
//   Path: each result passes the read stage (store read) and then the
//   output register on its way to cmd_out. Throughput: one item per
//   cycle while cmd_out is not stalled; decoder state, pointers
//   and the fill count update in the accept cycle, and the command store
//   takes one write or one read per cycle, so a pop directly after a
//   queued frame already sees that frame.
//   Reset: decoder, pointers and fill count clear at once; the store
//   needs no clearing since only written entries can ever be popped.
//   Stall: a result waiting on cmd_out does not block input; one more
//   item is taken into the read stage, after which cmd_in.ready drops
//   until cmd_out drains.
// ----------------------------------------------------------------------------
module slip_command_frame_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	scfq_in_if.sink     cmd_in,
	scfq_out_if.source  cmd_out
);
	import scfq_pkg::*;

	// Decoder state
	logic [7:0]        frame_q [BUF_SLOTS];
	logic [BCNT_W-1:0] byte_cnt_q;
	logic              esc_q;

	// Command store and its bookkeeping
	entry_t            cmd_store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  entry_cnt_q;

	// Read stage
	logic              valid_s1;
	status_t           status_s1;
	logic [CNT_W-1:0]  count_s1;
	entry_t            rd_data_s1;

	// Output register
	logic              out_valid_q;
	status_t           out_status_q;
	entry_t            out_entry_q;
	logic [CNT_W-1:0]  out_count_q;

	// Next-state signals
	logic              accept;
	logic              adv_s1;
	logic [7:0]        dec_byte;
	logic              is_data;
	status_t           status_d;
	logic              buf_we;
	logic              buf_clr;
	logic              wr_en;
	logic              rd_en;
	logic [BCNT_W-1:0] byte_cnt_d;
	logic              esc_d;
	logic [PTR_W-1:0]  wr_ptr_d;
	logic [PTR_W-1:0]  rd_ptr_d;
	logic [CNT_W-1:0]  entry_cnt_d;
	entry_t            wr_entry;

	// Handshake: the read stage drains into the output register whenever
	// that register is free or being taken this cycle.
	assign adv_s1       = valid_s1 && (!out_valid_q || cmd_out.ready);
	assign cmd_in.ready = !valid_s1 || adv_s1;
	assign accept       = cmd_in.valid && cmd_in.ready;

	// A byte after an escape is always data; otherwise only non-framing
	// codes are.
	assign dec_byte = esc_q ? unescape(cmd_in.rx_byte) : cmd_in.rx_byte;
	assign is_data  = esc_q || ((cmd_in.rx_byte != FEND) &&
	                            (cmd_in.rx_byte != FESC));

	always_comb begin
		status_d    = ST_ABSORBED;
		buf_we      = 1'b0;
		buf_clr     = 1'b0;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		byte_cnt_d  = byte_cnt_q;
		esc_d       = esc_q;
		wr_ptr_d    = wr_ptr_q;
		rd_ptr_d    = rd_ptr_q;
		entry_cnt_d = entry_cnt_q;
		if (cmd_in.op == OP_POP) begin
			if (entry_cnt_q == '0) begin
				status_d = ST_POP_EMPTY;
			end else begin
				status_d    = ST_POP_OK;
				rd_en       = 1'b1;
				entry_cnt_d = entry_cnt_q - CNT_W'(1);
				rd_ptr_d    = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
				                                                    : rd_ptr_q + PTR_W'(1);
			end
		end else if (is_data) begin
			esc_d = 1'b0;
			if (byte_cnt_q >= BCNT_W'(FRAME_BYTES)) begin
				// Overlong frame: drop it, keep stale buffer contents.
				status_d   = ST_TOO_LONG;
				byte_cnt_d = '0;
			end else begin
				buf_we     = 1'b1;
				byte_cnt_d = byte_cnt_q + BCNT_W'(1);
			end
		end else if (cmd_in.rx_byte == FEND) begin
			if (byte_cnt_q != '0) begin
				byte_cnt_d = '0;
				if (entry_cnt_q == CNT_W'(QUEUE_DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					status_d    = ST_QUEUED;
					wr_en       = 1'b1;
					buf_clr     = 1'b1;
					entry_cnt_d = entry_cnt_q + CNT_W'(1);
					wr_ptr_d    = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
					                                                    : wr_ptr_q + PTR_W'(1);
				end
			end
		end else begin
			esc_d = 1'b1;
		end
	end

	always_comb begin
		wr_entry.tag = (frame_q[0][7:6]) & TAG_MASK;
		for (int i = 0; i < BUF_SLOTS; i++) begin
			wr_entry.bytes[i] = frame_q[i];
		end
	end

	// Decoder and queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUF_SLOTS; i++) begin
				frame_q[i] <= '0;
			end
			byte_cnt_q  <= '0;
			esc_q       <= 1'b0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			entry_cnt_q <= '0;
		end else if (accept) begin
			if (buf_clr) begin
				for (int i = 0; i < BUF_SLOTS; i++) begin
					frame_q[i] <= '0;
				end
			end else if (buf_we) begin
				frame_q[byte_cnt_q[SLOT_W-1:0]] <= dec_byte;
			end
			byte_cnt_q  <= byte_cnt_d;
			esc_q       <= esc_d;
			wr_ptr_q    <= wr_ptr_d;
			rd_ptr_q    <= rd_ptr_d;
			entry_cnt_q <= entry_cnt_d;
		end
	end

	// Command store: one write or one registered read per cycle. A pop and
	// a queued frame never share a cycle, and a write lands before any
	// later read, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			cmd_store_q[wr_ptr_q] <= wr_entry;
		end
		if (accept && rd_en) begin
			rd_data_s1 <= cmd_store_q[rd_ptr_q];
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			count_s1  <= entry_cnt_d;
		end
	end

	// Output register: hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (cmd_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_status_q <= status_s1;
			out_count_q  <= count_s1;
			// Only a successful pop shows store data.
			out_entry_q  <= (status_s1 == ST_POP_OK) ? rd_data_s1 : '0;
		end
	end

	assign cmd_out.valid        = out_valid_q;
	assign cmd_out.status       = out_status_q;
	assign cmd_out.queue_sel    = out_entry_q.tag;
	assign cmd_out.cmd_code     = out_entry_q.bytes[0];
	assign cmd_out.param_one    = out_entry_q.bytes[1];
	assign cmd_out.param_two    = out_entry_q.bytes[2];
	assign cmd_out.param_three  = out_entry_q.bytes[3];
	assign cmd_out.param_four   = out_entry_q.bytes[4];
	assign cmd_out.param_five   = out_entry_q.bytes[5];
	assign cmd_out.param_six    = out_entry_q.bytes[6];
	assign cmd_out.queued_count = out_count_q;

	// Fill count stays within the store.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond store depth");

	// Frame byte count never passes the frame limit.
	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q <= BCNT_W'(FRAME_BYTES))
		else $error("byte count beyond frame limit");

	// A successful pop removes exactly one entry.
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd_in.op == OP_POP) && (entry_cnt_q != '0)
		|=> entry_cnt_q == $past(entry_cnt_q) - CNT_W'(1))
		else $error("pop did not decrement entry count");

	// Store data is visible only on a successful pop.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q != ST_POP_OK) |-> out_entry_q == '0)
		else $error("command fields not cleared on non-pop result");

	// A queued frame clears the decoder for the next frame.
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && wr_en |=> (byte_cnt_q == '0) && (frame_q[0] == '0))
		else $error("decoder not reset after queued frame");

endmodule

FILE: tb/scfq_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfq_tb_pkg
// Result type and command queue scoreboard for the SLIP frame queue bench.
// ----------------------------------------------------------------------------
package scfq_tb_pkg;
	import scfq_pkg::*;

	typedef struct packed {
		status_t                   status;
		logic [1:0]                queue_sel;
		logic [BUF_SLOTS-1:0][7:0] cmd_bytes;     // [0] command code, [1..6] parameters
		logic [CNT_W-1:0]          queued_count;
	} cmd_result_t;

	class frame_queue_scoreboard;
		// decoder image
		logic [BUF_SLOTS-1:0][7:0] frame_buf;
		int unsigned               frame_fill;
		bit                        esc_pending;
		// command store image
		logic [1:0]                store_tag   [QUEUE_DEPTH];
		logic [BUF_SLOTS-1:0][7:0] store_bytes [QUEUE_DEPTH];
		int unsigned               wr_ptr;
		int unsigned               rd_ptr;
		int unsigned               held;

		cmd_result_t expected_results[$];
		string       byte_names[BUF_SLOTS];
		int unsigned mismatches;
		int unsigned results_checked;
		int unsigned status_seen[8];

		function new();
			byte_names = '{"cmd_code", "param_one", "param_two", "param_three",
				"param_four", "param_five", "param_six"};
			frame_buf = '0;
			frame_fill = 0;
			esc_pending = 1'b0;
			wr_ptr = 0;
			rd_ptr = 0;
			held = 0;
			mismatches = 0;
			results_checked = 0;
			foreach (status_seen[i]) begin
				status_seen[i] = 0;
			end
		endfunction

		function status_t store_data(logic [7:0] b);
			if (frame_fill >= FRAME_BYTES) begin
				// overlong frame: drop the byte, keep stale buffer contents
				frame_fill = 0;
				return ST_TOO_LONG;
			end
			frame_buf[frame_fill] = b;
			frame_fill++;
			return ST_ABSORBED;
		endfunction

		function status_t close_frame();
			frame_fill = 0;
			if (held >= QUEUE_DEPTH) begin
				return ST_FULL;
			end
			store_tag[wr_ptr] = frame_buf[0][7:6];
			store_bytes[wr_ptr] = frame_buf;
			frame_buf = '0;
			wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
			held++;
			return ST_QUEUED;
		endfunction

		// Note one accepted transaction and queue the result it must produce.
		function void note_input(op_t op, logic [7:0] rx);
			cmd_result_t r;
			logic [7:0]  b;
			r = '0;
			b = rx;
			if (op == OP_BYTE) begin
				if (esc_pending) begin
					esc_pending = 1'b0;
					if (b == TFEND) begin
						b = FEND;
					end else if (b == TFESC) begin
						b = FESC;
					end
					r.status = store_data(b);
				end else if (b == FEND) begin
					r.status = (frame_fill == 0) ? ST_ABSORBED : close_frame();
				end else if (b == FESC) begin
					esc_pending = 1'b1;
					r.status = ST_ABSORBED;
				end else begin
					r.status = store_data(b);
				end
			end else if (held == 0) begin
				r.status = ST_POP_EMPTY;
			end else begin
				r.status = ST_POP_OK;
				r.queue_sel = store_tag[rd_ptr];
				r.cmd_bytes = store_bytes[rd_ptr];
				rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
				held--;
			end
			r.queued_count = CNT_W'(held);
			status_seen[r.status]++;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		// Check one result against the oldest expectation.
		function void check_result(cmd_result_t got);
			cmd_result_t want;
			if (expected_results.size() == 0) begin
				$error("status: expected no result, got %0h", got.status);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			results_checked++;
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("queue_sel", 8'(want.queue_sel), 8'(got.queue_sel));
			for (int i = 0; i < BUF_SLOTS; i++) begin
				compare_field(byte_names[i], want.cmd_bytes[i], got.cmd_bytes[i]);
			end
			compare_field("queued_count", 8'(want.queued_count), 8'(got.queued_count));
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for slip_command_frame_queue_core: directed SLIP frames
// and pops, then randomized frame traffic under varying flow control.
// ----------------------------------------------------------------------------
module tb;
	import scfq_pkg::*;
	import scfq_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned ITEM_TARGET  = 1750;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n;

	scfq_in_if  cmd_in ();
	scfq_out_if cmd_out ();

	slip_command_frame_queue_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (cmd_in),
		.cmd_out (cmd_out)
	);

	frame_queue_scoreboard sb;

	int unsigned items_sent;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct;
	int unsigned recv_stall_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Result side: stall at random, changing ready only on the falling edge.
	always @(negedge clk) begin
		cmd_out.ready <= (arst_n === 1'b1) && ($urandom_range(99) >= recv_stall_pct);
	end

	// Sample every result transaction on the rising edge and hand it to the scoreboard.
	always @(posedge clk) begin : result_monitor
		cmd_result_t got;
		if (arst_n === 1'b1 && cmd_out.valid === 1'b1 && cmd_out.ready === 1'b1) begin
			got.status       = cmd_out.status;
			got.queue_sel    = cmd_out.queue_sel;
			got.cmd_bytes[0] = cmd_out.cmd_code;
			got.cmd_bytes[1] = cmd_out.param_one;
			got.cmd_bytes[2] = cmd_out.param_two;
			got.cmd_bytes[3] = cmd_out.param_three;
			got.cmd_bytes[4] = cmd_out.param_four;
			got.cmd_bytes[5] = cmd_out.param_five;
			got.cmd_bytes[6] = cmd_out.param_six;
			got.queued_count = cmd_out.queued_count;
			sb.check_result(got);
		end
	end

	// Drive one input transaction. Enter and leave on a falling edge; hold
	// valid across back-to-back items, drop it only for a random idle gap.
	task automatic send_item(input op_t op, input logic [7:0] b);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			cmd_in.valid <= 1'b0;
			do begin
				@(negedge clk);
			end while ($urandom_range(99) < sender_idle_pct);
		end
		cmd_in.valid   <= 1'b1;
		cmd_in.op      <= op;
		cmd_in.rx_byte <= b;
		@(posedge clk);
		while (cmd_in.ready !== 1'b1) begin
			@(posedge clk);
		end
		sb.note_input(op, b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(OP_BYTE, b);
	endtask

	// The byte field is ignored on a pop; keep it random anyway.
	task automatic send_pop();
		send_item(OP_POP, 8'($urandom_range(255)));
	endtask

	// Send one payload byte, escaping the framing codes. Now and then escape
	// an ordinary byte too, which the decoder must pass through unchanged.
	task automatic send_payload(input logic [7:0] b);
		if (b == FEND) begin
			send_byte(FESC);
			send_byte(TFEND);
		end else if (b == FESC) begin
			send_byte(FESC);
			send_byte(TFESC);
		end else if ($urandom_range(99) < 6) begin
			send_byte(FESC);
			send_byte(b);
		end else begin
			send_byte(b);
		end
	endtask

	// Favor the framing codes so escapes show up often.
	function automatic logic [7:0] pick_payload_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 12) begin
			return FEND;
		end else if (r < 24) begin
			return FESC;
		end else if (r < 28) begin
			return TFEND;
		end else if (r < 32) begin
			return TFESC;
		end
		return 8'($urandom_range(255));
	endfunction

	// One frame, mostly well formed, with pops mixed in at the given rate.
	task automatic send_random_frame(input int unsigned pop_pct);
		int unsigned len;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) begin
			len = FRAME_BYTES + 1 + $urandom_range(1);   // overlong
		end else if (r < 12) begin
			len = 0;                                      // bare END
		end else begin
			len = $urandom_range(FRAME_BYTES, 1);
		end
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 4) begin
				send_byte(8'($urandom_range(255)));        // raw noise, may cut the frame
			end else begin
				send_payload(pick_payload_byte());
			end
			if ($urandom_range(99) < pop_pct) begin
				send_pop();
			end
		end
		// Stray escape before END turns the END into a data byte.
		if ($urandom_range(99) < 3) begin
			send_byte(FESC);
		end
		send_byte(FEND);
		while ($urandom_range(99) < pop_pct) begin
			send_pop();
		end
	endtask

	task automatic run_directed();
		send_pop();                  // pop from an empty store
		send_byte(FEND);             // END with nothing collected
		// Full-length frame: top tag bits set, both escape codes, an escaped
		// ordinary byte, and data extremes.
		send_byte(8'hFF);
		send_byte(FESC);
		send_byte(TFEND);
		send_byte(FESC);
		send_byte(TFESC);
		send_byte(FESC);
		send_byte(8'h41);
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(FEND);
		send_pop();
		// Overlong frame: the eighth byte discards it, buffer keeps its bytes.
		for (int i = 0; i < FRAME_BYTES + 1; i++) begin
			send_byte(8'h10 + 8'(i));
		end
		// Short frame afterwards carries the stale bytes in its tail.
		send_byte(8'h55);
		send_byte(FEND);
		send_pop();
	endtask

	task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned stop_at);
		int unsigned pop_pct;
		int unsigned frames_left;
		sender_idle_pct = idle_pct;
		recv_stall_pct  = stall_pct;
		frames_left = 0;
		pop_pct = 0;
		while (items_sent < stop_at) begin
			// Switch between filling the store to full and draining it to empty.
			if (frames_left == 0) begin
				case ($urandom_range(2))
					0: begin
						pop_pct = 3;
					end
					1: begin
						pop_pct = 30;
					end
					default: begin
						pop_pct = 70;
					end
				endcase
				frames_left = $urandom_range(30, 10);
			end
			send_random_frame(pop_pct);
			frames_left--;
		end
	endtask

	initial begin
		int unsigned phase_len;
		sb = new();
		items_sent = 0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		cmd_in.valid = 1'b0;
		cmd_in.op = OP_BYTE;
		cmd_in.rx_byte = 8'h00;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();

		// Flow-control phases: none, sender idle, receiver stall, both, none.
		phase_len = (ITEM_TARGET - items_sent) / 5;
		run_random_phase(0, 0, items_sent + phase_len);
		run_random_phase(55, 0, items_sent + phase_len);
		run_random_phase(0, 55, items_sent + phase_len);
		run_random_phase(28, 28, items_sent + phase_len);
		run_random_phase(0, 0, ITEM_TARGET);
		cmd_in.valid <= 1'b0;

		// Drain outstanding results, then allow for anything extra to show up.
		recv_stall_pct = 0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d transactions: %0d frames queued, %0d overlong, %0d dropped full",
			items_sent, sb.status_seen[ST_QUEUED], sb.status_seen[ST_TOO_LONG],
			sb.status_seen[ST_FULL]);
		$display("Pops: %0d returned a command, %0d hit an empty store; %0d field mismatches",
			sb.status_seen[ST_POP_OK], sb.status_seen[ST_POP_EMPTY], sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
